// ===== design/chm_pkg.sv =====
// shared constants and types for the chained hash map
package chm_pkg;
  localparam int MaxBuckets = 16;
  localparam int PoolNodes = 64;
  localparam int KeyBytes = 8;
  localparam int NodeW = $clog2(PoolNodes);
  localparam int LinkW = NodeW + 1;
  localparam int BucketW = $clog2(MaxBuckets);
  localparam int CountW = 7;
  localparam int SumW = 11;
  localparam logic [LinkW-1:0] NilNode = LinkW'(PoolNodes);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

  typedef struct packed {
    logic             we;
    logic [NodeW-1:0] addr;
    logic [63:0]      key;
    logic [63:0]      value;
    logic [LinkW-1:0] next;
    logic             we_key;
    logic             we_value;
    logic             we_next;
  } node_wr_t;
endpackage

// ===== design/chm_node_ram.sv =====
// node pool memory: key, value and next link per node
module chm_node_ram import chm_pkg::*; (
  input  logic             clk,
  input  logic [NodeW-1:0] rd_addr,
  input  node_wr_t         wr,
  output logic [63:0]      rd_key,
  output logic [63:0]      rd_value,
  output logic [LinkW-1:0] rd_next
);
  logic [63:0]      key_mem   [PoolNodes];
  logic [63:0]      value_mem [PoolNodes];
  logic [LinkW-1:0] next_mem  [PoolNodes];

  always_ff @(posedge clk) begin
    if (wr.we && wr.we_key) key_mem[wr.addr] <= wr.key;
    if (wr.we && wr.we_value) value_mem[wr.addr] <= wr.value;
    if (wr.we && wr.we_next) next_mem[wr.addr] <= wr.next;
    rd_key   <= key_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
    rd_next  <= next_mem[rd_addr];
  end
endmodule

// ===== design/chm_free_ram.sv =====
// free node stack memory; entries never written are resolved by the top level
module chm_free_ram import chm_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [NodeW-1:0] wr_addr,
  input  logic [NodeW-1:0] wr_data,
  input  logic [NodeW-1:0] rd_addr,
  output logic [NodeW-1:0] rd_data
);
  logic [NodeW-1:0] mem [PoolNodes];

  always_ff @(posedge clk) begin
    if (we) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== design/chained_hash_map.sv =====
// top level of the chained hash map
// One command is taken when start is high and busy is low; its single result
// appears for one cycle with done high, and the receiver cannot stall it.
// Each node costs one read of the node memory and one compare, and the bucket
// remainder is formed by restoring trial subtracts in S_MOD. done rises in the first
// cycle that busy is low. Free-stack entries below the lowest stack level ever
// reached count as holding their own index, so no clearing pass follows reset.
module chained_hash_map import chm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_data,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command,
  input  logic [63:0]         key,
  input  logic [63:0]         value,
  output logic                done,
  output logic [2:0]          status,
  output logic [63:0]         found_value,
  output logic [CountW-1:0]   entry_count
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HASH  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_REQ   = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_FREE  = 7'b0100000,
    S_ALLOC = 7'b1000000
  } state_t;

  state_t state;
  logic [4:0]         bucket_count;
  logic [LinkW-1:0]   bucket_head [MaxBuckets];
  logic [LinkW-1:0]   free_top;
  logic [NodeW:0]     free_low;
  logic [CountW-1:0]  stored_count;
  logic [1:0]         cmd;
  logic [63:0]        key_r, value_r;
  logic [SumW-1:0]    sum;
  logic [4:0]         divisor;
  logic [3:0]         mod_sh;
  logic [SumW-1:0]    rem_next;
  logic [SumW+4:0]    trial;
  logic [BucketW-1:0] bucket;
  logic [LinkW-1:0]   cur, prev;
  logic [NodeW:0]     steps;
  logic [63:0]        rd_key, rd_value;
  logic [LinkW-1:0]   rd_next;
  logic [NodeW-1:0]   free_rd;
  logic [NodeW-1:0]   free_addr;
  node_wr_t           nwr;
  logic               fwe;
  logic [NodeW-1:0]   fwa, fwd;
  logic [SumW-1:0]    byte_sum;
  logic               link_pend;
  logic [NodeW-1:0]   nxt_prev, nxt_fresh;

  always_comb begin
    byte_sum = '0;
    for (int i = 0; i < KeyBytes; i++) byte_sum = byte_sum + SumW'(key_r[8*i +: 8]);
  end

  // restoring remainder, up to four trial subtracts per cycle from shift mod_sh down
  always_comb begin
    rem_next = sum;
    trial    = '0;
    for (int j = 0; j < 4; j++) begin
      if (mod_sh >= 4'(j)) begin
        trial = (SumW+5)'(divisor) << (mod_sh - 4'(j));
        if ({5'd0, rem_next} >= trial) rem_next = rem_next - SumW'(trial);
      end
    end
  end

  chm_node_ram u_node (
    .clk(clk), .rd_addr(cur[NodeW-1:0]), .wr(nwr),
    .rd_key(rd_key), .rd_value(rd_value), .rd_next(rd_next)
  );

  assign free_addr = NodeW'(free_top - LinkW'(1));
  chm_free_ram u_free (
    .clk(clk), .we(fwe), .wr_addr(fwa), .wr_data(fwd),
    .rd_addr(free_addr), .rd_data(free_rd)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    nwr.we <= 1'b0;
    fwe    <= 1'b0;
    done   <= 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      bucket_count <= 5'd10;
      free_top     <= LinkW'(PoolNodes);
      free_low     <= (NodeW+1)'(PoolNodes);
      stored_count <= '0;
      for (int i = 0; i < MaxBuckets; i++) bucket_head[i] <= NilNode;
    end else begin
      if (cfg_we) bucket_count <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd     <= command;
            key_r   <= key;
            value_r <= value;
            divisor <= (bucket_count == 5'd0) ? 5'd1 :
                       (bucket_count > 5'(MaxBuckets)) ? 5'(MaxBuckets) : bucket_count;
            state   <= S_HASH;
          end
        end
        S_HASH: begin
          sum    <= byte_sum;
          mod_sh <= 4'd10;
          state  <= S_MOD;
        end
        S_MOD: begin
          sum <= rem_next;
          if (mod_sh < 4'd4) begin
            bucket <= rem_next[BucketW-1:0];
            cur    <= bucket_head[rem_next[BucketW-1:0]];
            prev   <= NilNode;
            steps  <= '0;
            state  <= S_REQ;
          end else begin
            mod_sh <= mod_sh - 4'd4;
          end
        end
        S_REQ: begin
          if (cur >= NilNode || steps >= (NodeW+1)'(PoolNodes)) begin
            cur   <= NilNode;
            state <= S_FREE;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rd_key == key_r) begin
            state <= S_FREE;
          end else begin
            prev  <= cur;
            cur   <= rd_next;
            steps <= steps + 1'b1;
            state <= S_REQ;
          end
        end
        S_FREE: begin
          done        <= 1'b1;
          status      <= ST_NOT_FOUND;
          found_value <= '0;
          entry_count <= stored_count;
          state       <= S_IDLE;
          case (cmd)
            CMD_INSERT: begin
              if (cur < NilNode) begin
                nwr <= '{we: 1'b1, addr: cur[NodeW-1:0], key: key_r, value: value_r,
                         next: NilNode, we_key: 1'b0, we_value: 1'b1, we_next: 1'b0};
                status <= ST_UPDATED;
              end else if (free_top == '0) begin
                status <= ST_FULL;
              end else begin
                done  <= 1'b0;
                state <= S_ALLOC;
              end
            end
            CMD_SEARCH: begin
              if (cur < NilNode) begin
                status      <= ST_FOUND;
                found_value <= rd_value;
              end
            end
            CMD_REMOVE: begin
              if (cur < NilNode && free_top < LinkW'(PoolNodes)) begin
                if (prev < NilNode)
                  nwr <= '{we: 1'b1, addr: prev[NodeW-1:0], key: key_r, value: value_r,
                           next: rd_next, we_key: 1'b0, we_value: 1'b0, we_next: 1'b1};
                else
                  bucket_head[bucket] <= rd_next;
                fwe      <= 1'b1;
                fwa      <= free_top[NodeW-1:0];
                fwd      <= cur[NodeW-1:0];
                free_top <= free_top + 1'b1;
                if (stored_count != '0) begin
                  stored_count <= stored_count - 1'b1;
                  entry_count  <= stored_count - 1'b1;
                end
                status <= ST_REMOVED;
              end
            end
            default: ;
          endcase
        end
        S_ALLOC: begin
          // free stack entry below the lowest level reached counts as holding its own index
          logic [NodeW-1:0] fresh;
          fresh = ({1'b0, free_addr} >= free_low) ? free_rd : free_addr;
          if ({1'b0, free_addr} < free_low) free_low <= {1'b0, free_addr};
          nwr <= '{we: 1'b1, addr: fresh, key: key_r, value: value_r,
                   next: NilNode, we_key: 1'b1, we_value: 1'b1, we_next: 1'b1};
          if (prev < NilNode) begin
            // the tail link write waits in link_pend and follows on the same node write port
            nxt_prev    <= prev[NodeW-1:0];
            nxt_fresh   <= fresh;
            link_pend   <= 1'b1;
          end else begin
            bucket_head[bucket] <= LinkW'(fresh);
          end
          free_top     <= free_top - 1'b1;
          stored_count <= stored_count + 1'b1;
          entry_count  <= stored_count + 1'b1;
          status       <= ST_INSERTED;
          found_value  <= '0;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (link_pend) begin
        link_pend <= 1'b0;
        nwr <= '{we: 1'b1, addr: nxt_prev, key: key_r, value: value_r,
                 next: LinkW'(nxt_fresh), we_key: 1'b0, we_value: 1'b0, we_next: 1'b1};
      end
    end
    if (rst) link_pend <= 1'b0;
  end
endmodule

// ===== design/chm_checker.sv =====
// port-level assertions for the chained hash map, bound to the top level
module chm_checker import chm_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [2:0]        status,
  input logic [63:0]       found_value,
  input logic [CountW-1:0] entry_count
);
  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("command not taken");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result longer than one cycle");
  a_fv: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_FOUND) |-> found_value == '0)
    else $error("value on a result that is not a found search");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= CountW'(PoolNodes))
    else $error("entry count beyond pool");
endmodule

bind chained_hash_map chm_checker u_chm_checker (.*);
